[sv/qs_pkg.sv]
`timescale 1ns / 1ps

package qs_pkg;

	localparam int VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

endpackage

[sv/qs_elem_mem.sv]
`timescale 1ns / 1ps

module qs_elem_mem #(
	parameter int AW = 6,
	parameter int N  = 64
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  qs_pkg::value_t  wdata,
	input  logic [AW-1:0]   raddr,
	output qs_pkg::value_t  rdata
);
	import qs_pkg::*;

	value_t mem [N];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/qs_stack_mem.sv]
`timescale 1ns / 1ps

module qs_stack_mem #(
	parameter int AW = 6,
	parameter int N  = 64,
	parameter int W  = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [N];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/quicksort_engine.sv]
`timescale 1ns / 1ps
// The item with last set ends loading; it starts the sort, or output for one item.
// Sort: pop a range, read its pivot at hi, scan both ends, swap, place the pivot,
// push the parts, end on an empty stack; the RAMs have one read and one write port.
// Output: results go from the element RAM to the result register once it is free.
// arst_n clears state, counts, drop flag and res_valid; RAMs hold no reset values.
module quicksort_engine #(
	parameter int DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  qs_pkg::value_t value,
	input  logic           last,
	output logic           res_valid,
	input  logic           res_ready,
	output qs_pkg::value_t value_res,
	output logic           last_res,
	output logic           overflow
);
	import qs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam int SW = 2 * AW;

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_POP    = 4'd1;
	localparam logic [3:0] S_RANGE  = 4'd2;
	localparam logic [3:0] S_PIV    = 4'd3;
	localparam logic [3:0] S_SCAN_I = 4'd4;
	localparam logic [3:0] S_SCAN_J = 4'd5;
	localparam logic [3:0] S_SWAP   = 4'd6;
	localparam logic [3:0] S_FIN1   = 4'd7;
	localparam logic [3:0] S_FIN2   = 4'd8;
	localparam logic [3:0] S_OUT_RD = 4'd9;
	localparam logic [3:0] S_OUT_LD = 4'd10;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] sp_q;
	logic          dropped_q;
	logic [AW-1:0] lo_q, hi_q, i_q, j_q, k_q;
	value_t        pivot_q, ei_q, ej_q;

	logic          res_valid_q, last_res_q, overflow_q;
	value_t        value_res_q;

	logic          e_we;
	logic [AW-1:0] e_waddr, e_raddr;
	value_t        e_wdata, e_rdata;
	logic          s_we;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [SW-1:0] s_wdata, s_rdata;

	logic          accept, has_room, i_lt_j, scan_i_go, scan_j_go, out_free;
	logic          push_l, push_r, rng_ok, sp_room;
	logic [CW-1:0] n_total;
	logic [AW-1:0] s_lo, s_hi;

	qs_elem_mem #(.AW(AW), .N(DEPTH)) u_elem (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	qs_stack_mem #(.AW(AW), .N(DEPTH), .W(SW)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign item_ready = (state_q == S_LOAD);
	assign accept     = item_valid && item_ready;
	assign has_room   = (count_q < CW'(DEPTH));
	assign n_total    = has_room ? count_q + CW'(1) : count_q;
	assign sp_room    = (sp_q < CW'(DEPTH));
	assign s_lo       = s_rdata[SW-1:AW];
	assign s_hi       = s_rdata[AW-1:0];
	assign rng_ok     = (s_lo < s_hi);
	assign i_lt_j     = (i_q < j_q);
	assign scan_i_go  = (i_q < hi_q) && (e_rdata < pivot_q);
	assign scan_j_go  = (pivot_q < e_rdata) && i_lt_j;
	// pivot at index i: left part needs two or more elements, same for the right
	assign push_l     = ({1'b0, i_q} > {1'b0, lo_q} + CW'(1));
	assign push_r     = ({1'b0, i_q} + CW'(1) < {1'b0, hi_q});
	assign out_free   = !res_valid_q || res_ready;

	always_comb begin
		e_we    = 1'b0;
		e_waddr = i_q;
		e_wdata = value;
		e_raddr = i_q;
		s_we    = 1'b0;
		s_waddr = sp_q[AW-1:0];
		s_wdata = {lo_q, hi_q};
		s_raddr = AW'(sp_q - CW'(1));
		case (state_q)
			S_LOAD: begin
				e_we    = accept && has_room;
				e_waddr = count_q[AW-1:0];
				e_wdata = value;
				s_we    = accept && last && (n_total >= CW'(2));
				s_waddr = '0;
				s_wdata = {AW'(0), AW'(n_total - CW'(1))};
			end
			S_RANGE: begin
				e_raddr = s_hi;
			end
			S_SCAN_I: begin
				if (scan_i_go) begin
					e_raddr = i_q + AW'(1);
				end else begin
					e_raddr = j_q - AW'(1);
				end
			end
			S_SCAN_J: begin
				if (scan_j_go) begin
					e_raddr = j_q - AW'(1);
				end else if (i_lt_j) begin
					e_we    = 1'b1;
					e_waddr = j_q;
					e_wdata = ei_q;
				end
			end
			S_SWAP: begin
				e_we    = 1'b1;
				e_waddr = i_q;
				e_wdata = ej_q;
				e_raddr = i_q + AW'(1);
			end
			S_FIN1: begin
				e_we    = 1'b1;
				e_waddr = hi_q;
				e_wdata = ei_q;
				s_we    = push_l && sp_room;
				s_wdata = {lo_q, i_q - AW'(1)};
			end
			S_FIN2: begin
				e_we    = 1'b1;
				e_waddr = i_q;
				e_wdata = pivot_q;
				s_we    = push_r && sp_room;
				s_wdata = {i_q + AW'(1), hi_q};
			end
			S_OUT_RD: begin
				e_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			sp_q        <= '0;
			dropped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						count_q <= n_total;
						if (!has_room) begin
							dropped_q <= 1'b1;
						end
						if (last) begin
							k_q <= '0;
							if (n_total >= CW'(2)) begin
								sp_q    <= CW'(1);
								state_q <= S_POP;
							end else begin
								sp_q    <= '0;
								state_q <= S_OUT_RD;
							end
						end
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						k_q     <= '0;
						state_q <= S_OUT_RD;
					end else begin
						sp_q    <= sp_q - CW'(1);
						state_q <= S_RANGE;
					end
				end
				S_RANGE: begin
					lo_q <= s_lo;
					hi_q <= s_hi;
					i_q  <= s_lo;
					j_q  <= s_hi;
					state_q <= rng_ok ? S_PIV : S_POP;
				end
				S_PIV: begin
					pivot_q <= e_rdata;
					state_q <= S_SCAN_I;
				end
				S_SCAN_I: begin
					if (scan_i_go) begin
						i_q <= i_q + AW'(1);
					end else begin
						ei_q <= e_rdata;
						if (i_lt_j) begin
							j_q     <= j_q - AW'(1);
							state_q <= S_SCAN_J;
						end else begin
							state_q <= S_FIN1;
						end
					end
				end
				S_SCAN_J: begin
					if (scan_j_go) begin
						j_q <= j_q - AW'(1);
					end else if (i_lt_j) begin
						ej_q    <= e_rdata;
						state_q <= S_SWAP;
					end else begin
						state_q <= S_FIN1;
					end
				end
				S_SWAP: begin
					i_q     <= i_q + AW'(1);
					state_q <= S_SCAN_I;
				end
				S_FIN1: begin
					if (push_l && sp_room) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if (push_r && sp_room) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= S_POP;
				end
				S_OUT_RD: begin
					if (out_free) begin
						state_q <= S_OUT_LD;
					end
				end
				S_OUT_LD: begin
					res_valid_q <= 1'b1;
					value_res_q <= e_rdata;
					overflow_q  <= dropped_q;
					if ({1'b0, k_q} + CW'(1) == count_q) begin
						last_res_q <= 1'b1;
						count_q    <= '0;
						dropped_q  <= 1'b0;
						state_q    <= S_LOAD;
					end else begin
						last_res_q <= 1'b0;
						k_q        <= k_q + AW'(1);
						state_q    <= S_OUT_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign value_res = value_res_q;
	assign last_res  = last_res_q;
	assign overflow  = overflow_q;

endmodule

[bench/tb_quicksort_engine.sv]
`timescale 1ns / 1ps

module tb_quicksort_engine;
	import qs_pkg::*;

	localparam int DEPTH = 64;
	localparam int ITEMS = 350;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 20000;
	localparam int TAIL_CYCLES = 64;
	localparam value_t VMIN = 32'sh8000_0000;
	localparam value_t VMAX = 32'sh7fff_ffff;

	typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_RISING, PAT_FALLING, PAT_EXTREME} pattern_t;

	// One offered item; typed rows carry their single result spelled out.
	typedef struct {
		value_t val;
		logic   lst;
		logic   typed;
		value_t exp_val;
		logic   exp_last;
		logic   exp_ovf;
	} row_t;

	typedef struct {
		value_t val;
		logic   lst;
		logic   ovf;
	} sorted_t;

	logic   clk;
	logic   arst_n;
	logic   item_valid;
	logic   item_ready;
	value_t value;
	logic   last;
	logic   res_valid;
	logic   res_ready;
	value_t value_res;
	logic   last_res;
	logic   overflow;

	row_t    directed_rows[$];
	row_t    offered_rows[$];
	sorted_t pending_sorted[$];
	value_t  batch_vals[$];
	logic    batch_dropped;

	bit rand_phase;
	int items_sent;
	int results_seen;
	int batches_done;
	int overflow_batches;
	int fail_count;
	int idle_cycles;

	quicksort_engine #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.value(value),
		.last(last),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.value_res(value_res),
		.last_res(last_res),
		.overflow(overflow)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Batch model: store up to DEPTH items, flag the rest, sort on last.
	task automatic absorb_item(value_t v, logic is_last);
		int i;
		int j;
		value_t key;
		if (batch_vals.size() < DEPTH)
			batch_vals.push_back(v);
		else
			batch_dropped = 1'b1;
		if (is_last) begin
			for (i = 1; i < batch_vals.size(); i++) begin
				key = batch_vals[i];
				j = i - 1;
				while (j >= 0 && batch_vals[j] > key) begin
					batch_vals[j + 1] = batch_vals[j];
					j--;
				end
				batch_vals[j + 1] = key;
			end
			for (i = 0; i < batch_vals.size(); i++)
				pending_sorted.push_back('{batch_vals[i], i == batch_vals.size() - 1,
					batch_dropped});
			if (batch_dropped)
				overflow_batches++;
			batches_done++;
			batch_vals.delete();
			batch_dropped = 1'b0;
		end
	endtask

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic value_t gen_value(pattern_t pat, int idx);
		case (pat)
			PAT_NARROW: return value_t'(int'($urandom_range(0, 8)) - 4);
			PAT_RISING: return value_t'(idx * 3 - 50);
			PAT_FALLING: return value_t'(1000 - idx * 7);
			PAT_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return VMIN;
					1: return VMAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic send_row(row_t r, int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		offered_rows.push_back(r);
		item_valid <= 1'b1;
		value <= r.val;
		last <= r.lst;
		items_sent++;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_batch(int n, pattern_t pat);
		row_t r;
		for (int i = 0; i < n; i++) begin
			r = '{gen_value(pat, i), i == n - 1, 1'b0, '0, 1'b0, 1'b0};
			send_row(r, pick_gap());
		end
	endtask

	// Sender
	initial begin
		int n;
		int batch_idx;
		pattern_t pat;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		value <= '0;
		last <= 1'b0;
		batch_dropped = 1'b0;

		// single-item batches: the result is the item itself
		directed_rows.push_back('{VMIN, 1'b1, 1'b1, VMIN, 1'b1, 1'b0});
		directed_rows.push_back('{VMAX, 1'b1, 1'b1, VMAX, 1'b1, 1'b0});
		directed_rows.push_back('{32'sd0, 1'b1, 1'b1, 32'sd0, 1'b1, 1'b0});
		directed_rows.push_back('{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b0});
		directed_rows.push_back('{32'sd1, 1'b1, 1'b1, 32'sd1, 1'b1, 1'b0});
		// extremes mixed
		directed_rows.push_back('{VMAX, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{VMIN, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{-32'sd1, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'sd1, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'sd0, 1'b1, 1'b0, '0, 1'b0, 1'b0});
		// duplicates
		directed_rows.push_back('{32'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{-32'sd3, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'sd7, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{-32'sd3, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'sd7, 1'b1, 1'b0, '0, 1'b0, 1'b0});
		// pair in reverse order
		directed_rows.push_back('{32'sd100, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{-32'sd100, 1'b1, 1'b0, '0, 1'b0, 1'b0});
		// already sorted
		directed_rows.push_back('{32'sd1, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'sd2, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'sd3, 1'b1, 1'b0, '0, 1'b0, 1'b0});
		// all equal
		directed_rows.push_back('{32'shaaaa_aaaa, 1'b0, 1'b0, '0, 1'b0, 1'b0});
		directed_rows.push_back('{32'shaaaa_aaaa, 1'b1, 1'b0, '0, 1'b0, 1'b0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_row(directed_rows[i], pick_gap());

		rand_phase = 1'b1;
		batch_idx = 0;
		while (items_sent < ITEMS) begin
			// a full batch first, then one that drops items with last on a dropped item
			if (batch_idx == 0)
				n = DEPTH;
			else if (batch_idx == 1)
				n = DEPTH + 3;
			else if ($urandom_range(0, 99) < 4)
				n = $urandom_range(DEPTH, DEPTH + 6);
			else
				n = $urandom_range(1, 12);
			pat = pattern_t'($urandom_range(0, 4));
			if (batch_idx < 2 || $urandom_range(0, 1))
				pat = PAT_RANDOM;
			send_batch(n, pat);
			batch_idx++;
		end
		item_valid <= 1'b0;
		// let the monitor take in the final item before looking at the queue
		@(posedge clk);

		while (pending_sorted.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sorted %0d batches from %0d items (%0d batches over capacity)",
			batches_done, items_sent, overflow_batches);
		$display("checked %0d results, %0d mismatches", results_seen, fail_count);
		if (fail_count == 0 && pending_sorted.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver: random stalls, one long hold early in the random part, then random stalls again
	initial begin
		int n;
		int k;
		res_ready <= 1'b0;
		@(posedge clk);
		while (!rand_phase) begin
			res_ready <= ($urandom_range(0, 3) != 0);
			@(posedge clk);
		end
		res_ready <= 1'b0;
		repeat (HOLD_CYCLES) @(posedge clk);
		forever begin
			k = $urandom_range(0, 99);
			if (k < 55) begin
				res_ready <= 1'b1;
				n = $urandom_range(1, 20);
			end else if (k < 92) begin
				res_ready <= 1'b0;
				n = $urandom_range(1, 3);
			end else begin
				res_ready <= 1'b0;
				n = $urandom_range(20, 60);
			end
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin : monitor
		row_t r;
		sorted_t e;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				r = offered_rows.pop_front();
				if (r.typed) begin
					pending_sorted.push_back('{r.exp_val, r.exp_last, r.exp_ovf});
					batch_vals.delete();
					batch_dropped = 1'b0;
					batches_done++;
				end else begin
					absorb_item(value, last);
				end
			end
			if (res_valid && res_ready) begin
				results_seen++;
				if (pending_sorted.size() == 0) begin
					$error("unexpected result: value_res=%0d last_res=%0b overflow=%0b",
						value_res, last_res, overflow);
					fail_count++;
				end else begin
					e = pending_sorted.pop_front();
					if (value_res !== e.val) begin
						$error("value_res: expected %0d, got %0d", e.val, value_res);
						fail_count++;
					end
					if (last_res !== e.lst) begin
						$error("last_res: expected %0b, got %0b", e.lst, last_res);
						fail_count++;
					end
					if (overflow !== e.ovf) begin
						$error("overflow: expected %0b, got %0b", e.ovf, overflow);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without progress", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

endmodule
